// ===== design/aabb_pair_collision_resolve_top_defines.svh =====
// Assertion macros used by the checker file of the box pair resolver.
`ifndef AABB_PAIR_COLLISION_RESOLVE_TOP_DEFINES_SVH
`define AABB_PAIR_COLLISION_RESOLVE_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AAPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define AAPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/aapc_pkg.sv =====
// Types and constants of the box pair collision resolver.
`default_nettype none
package aapc_pkg;
  localparam int PosW  = 24;
  localparam int SizeW = 16;
  localparam int MassW = 16;
  localparam int FlagW = 2;
  localparam int DistW = PosW + 1;     // doubled centre distance
  localparam int PenW  = SizeW + 1;    // doubled penetration, size sum
  localparam int DenW  = MassW + 2;    // doubled mass total
  localparam int RemW  = PenW + MassW + 1;
  localparam int QW    = 16;           // quotient bits, one per divider step
  localparam int MoveW = QW + 1;

  localparam int FlagTrigger   = 0;
  localparam int FlagKinematic = 1;

  typedef struct packed {
    logic hit;
    logic axis;
    logic a_low;
    logic a_kin;
    logic b_kin;
  } side_t;

  typedef struct packed {
    logic [RemW-1:0] rem_a;
    logic [RemW-1:0] rem_b;
    logic [DenW-1:0] den;
    logic [QW-1:0]   q_a;
    logic [QW-1:0]   q_b;
  } div_t;
endpackage
`default_nettype wire

// ===== design/aabb_pair_collision_resolve_top.sv =====
// Top level of the 2D box pair overlap and separation resolver.
//
//  channel | ports                               | direction
//  --------+-------------------------------------+----------
//  in      | in_valid, in_stall, in_a_x..b_flags | box pair in
//  out     | out_valid, out_stall, out_hit..     | moves out
//
// One item per cycle sustained while the output is not stalled. The path is
// three front stages (distance, axis choice, mass products), sixteen divider
// stages (one quotient bit each) and the output register.
// Reset (rst_n low, synchronous) clears every valid bit; data needs none.
// A stall on a valid output freezes the whole pipeline; in_stall follows a held
// output at once, so no item is lost or repeated.
`default_nettype none
module aabb_pair_collision_resolve_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [aapc_pkg::PosW-1:0]   in_a_x,
  input  wire logic [aapc_pkg::PosW-1:0]   in_a_y,
  input  wire logic [aapc_pkg::PosW-1:0]   in_b_x,
  input  wire logic [aapc_pkg::PosW-1:0]   in_b_y,
  input  wire logic [aapc_pkg::SizeW-1:0]  in_a_width,
  input  wire logic [aapc_pkg::SizeW-1:0]  in_a_height,
  input  wire logic [aapc_pkg::SizeW-1:0]  in_b_width,
  input  wire logic [aapc_pkg::SizeW-1:0]  in_b_height,
  input  wire logic [aapc_pkg::MassW-1:0]  in_a_mass,
  input  wire logic [aapc_pkg::MassW-1:0]  in_b_mass,
  input  wire logic [aapc_pkg::FlagW-1:0]  in_a_flags,
  input  wire logic [aapc_pkg::FlagW-1:0]  in_b_flags,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic                             out_hit,
  output logic                             out_axis,
  output logic signed [aapc_pkg::MoveW-1:0] out_a_move,
  output logic signed [aapc_pkg::MoveW-1:0] out_b_move
);
  import aapc_pkg::*;

  logic  en;
  logic  vld_s  [0:QW];
  side_t side_s [0:QW];
  div_t  div_s  [0:QW];

  logic                    out_valid_r, hit_r, axis_r;
  logic signed [MoveW-1:0] a_move_r, b_move_r;
  logic [QW-1:0]           a_mag, b_mag;
  logic signed [MoveW-1:0] a_move_nxt, b_move_nxt;

  // advance everything unless a finished item is held at the output
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  aapc_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_valid),
    .a_x      (in_a_x),
    .a_y      (in_a_y),
    .b_x      (in_b_x),
    .b_y      (in_b_y),
    .a_width  (in_a_width),
    .a_height (in_a_height),
    .b_width  (in_b_width),
    .b_height (in_b_height),
    .a_mass   (in_a_mass),
    .b_mass   (in_b_mass),
    .a_flags  (in_a_flags),
    .b_flags  (in_b_flags),
    .out_vld  (vld_s[0]),
    .out_side (side_s[0]),
    .out_div  (div_s[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar k = 0; k < QW; k++) begin : g_div
    aapc_div_step #(.Bit(QW - 1 - k)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_s[k]),
      .in_side  (side_s[k]),
      .in_div   (div_s[k]),
      .out_vld  (vld_s[k+1]),
      .out_side (side_s[k+1]),
      .out_div  (div_s[k+1])
    );
  end

  // drop the kinematic box's share, then point each move away from the other
  always_comb begin
    a_mag = side_s[QW].a_kin ? '0 : div_s[QW].q_a;
    b_mag = side_s[QW].b_kin ? '0 : div_s[QW].q_b;
    a_move_nxt = '0;
    b_move_nxt = '0;
    if (side_s[QW].hit) begin
      a_move_nxt = side_s[QW].a_low ? -$signed({1'b0, a_mag}) : $signed({1'b0, a_mag});
      b_move_nxt = side_s[QW].a_low ? $signed({1'b0, b_mag}) : -$signed({1'b0, b_mag});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vld_s[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r    <= side_s[QW].hit;
      axis_r   <= side_s[QW].axis;
      a_move_r <= a_move_nxt;
      b_move_r <= b_move_nxt;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_hit    = hit_r;
  assign out_axis   = axis_r;
  assign out_a_move = a_move_r;
  assign out_b_move = b_move_r;
endmodule
`default_nettype wire

// ===== design/aapc_geom.sv =====
// Front pipeline: overlap test, axis choice and mass products (three stages).
`default_nettype none
module aapc_geom (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire logic                        in_vld,
  input  wire logic [aapc_pkg::PosW-1:0]   a_x,
  input  wire logic [aapc_pkg::PosW-1:0]   a_y,
  input  wire logic [aapc_pkg::PosW-1:0]   b_x,
  input  wire logic [aapc_pkg::PosW-1:0]   b_y,
  input  wire logic [aapc_pkg::SizeW-1:0]  a_width,
  input  wire logic [aapc_pkg::SizeW-1:0]  a_height,
  input  wire logic [aapc_pkg::SizeW-1:0]  b_width,
  input  wire logic [aapc_pkg::SizeW-1:0]  b_height,
  input  wire logic [aapc_pkg::MassW-1:0]  a_mass,
  input  wire logic [aapc_pkg::MassW-1:0]  b_mass,
  input  wire logic [aapc_pkg::FlagW-1:0]  a_flags,
  input  wire logic [aapc_pkg::FlagW-1:0]  b_flags,
  output logic                             out_vld,
  output aapc_pkg::side_t                  out_side,
  output aapc_pkg::div_t                   out_div
);
  import aapc_pkg::*;

  // stage 1
  logic             v1_r;
  logic [DistW-1:0] dx2_r, dy2_r;
  logic [PenW-1:0]  sw_r, sh_r;
  logic             ltx_r, lty_r, trig_r, akin1_r, bkin1_r;
  logic [MassW-1:0] ma1_r, mb1_r;
  // stage 2
  logic             v2_r;
  logic [PenW-1:0]  pen_r;
  side_t            side2_r;
  logic [MassW-1:0] ma2_r, mb2_r;
  // stage 3
  logic             v3_r;
  side_t            side3_r;
  div_t             div3_r;

  logic signed [PosW:0] dx_s, dy_s;
  logic [PosW-1:0]      adx, ady;
  logic                 ovl, horiz, both_zero;
  logic [PenW-1:0]      px2, py2;

  always_comb begin
    dx_s = $signed({a_x[PosW-1], a_x}) - $signed({b_x[PosW-1], b_x});
    dy_s = $signed({a_y[PosW-1], a_y}) - $signed({b_y[PosW-1], b_y});
    adx  = dx_s[PosW] ? PosW'(-dx_s) : dx_s[PosW-1:0];
    ady  = dy_s[PosW] ? PosW'(-dy_s) : dy_s[PosW-1:0];
    ovl  = trig_r && (dx2_r < DistW'(sw_r)) && (dy2_r < DistW'(sh_r));
    px2  = sw_r - dx2_r[PenW-1:0];
    py2  = sh_r - dy2_r[PenW-1:0];
    horiz = px2 < py2;
    both_zero = (ma1_r == '0) && (mb1_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx2_r   <= {adx, 1'b0};
      dy2_r   <= {ady, 1'b0};
      sw_r    <= PenW'(a_width) + PenW'(b_width);
      sh_r    <= PenW'(a_height) + PenW'(b_height);
      ltx_r   <= $signed(a_x) < $signed(b_x);
      lty_r   <= $signed(a_y) < $signed(b_y);
      trig_r  <= !a_flags[FlagTrigger] && !b_flags[FlagTrigger];
      akin1_r <= a_flags[FlagKinematic];
      bkin1_r <= b_flags[FlagKinematic];
      ma1_r   <= a_mass;
      mb1_r   <= b_mass;

      side2_r.hit   <= ovl;
      side2_r.axis  <= ovl && !horiz;
      side2_r.a_low <= horiz ? ltx_r : lty_r;
      side2_r.a_kin <= akin1_r;
      side2_r.b_kin <= bkin1_r;
      pen_r         <= horiz ? px2 : py2;
      // both masses zero: split evenly
      ma2_r         <= both_zero ? MassW'(1) : ma1_r;
      mb2_r         <= both_zero ? MassW'(1) : mb1_r;

      side3_r      <= side2_r;
      div3_r.rem_a <= RemW'(pen_r * ma2_r);
      div3_r.rem_b <= RemW'(pen_r * mb2_r);
      div3_r.den   <= {DenW'(ma2_r) + DenW'(mb2_r)} << 1;
      div3_r.q_a   <= '0;
      div3_r.q_b   <= '0;
    end
  end

  assign out_vld  = v3_r;
  assign out_side = side3_r;
  assign out_div  = div3_r;
endmodule
`default_nettype wire

// ===== design/aapc_div_step.sv =====
// One restoring-division step, run on both mass shares side by side.
`default_nettype none
module aapc_div_step #(
  parameter int Bit = 15
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            en,
  input  wire logic            in_vld,
  input  wire aapc_pkg::side_t in_side,
  input  wire aapc_pkg::div_t  in_div,
  output logic                 out_vld,
  output aapc_pkg::side_t      out_side,
  output aapc_pkg::div_t       out_div
);
  import aapc_pkg::*;

  logic            vld_r;
  side_t           side_r;
  div_t            div_r;
  logic [RemW-1:0] sub;
  logic [RemW:0]   dif_a, dif_b;
  div_t            div_nxt;

  always_comb begin
    sub   = RemW'(in_div.den) << Bit;
    dif_a = {1'b0, in_div.rem_a} - {1'b0, sub};
    dif_b = {1'b0, in_div.rem_b} - {1'b0, sub};
    div_nxt = in_div;
    if (!dif_a[RemW]) begin
      div_nxt.rem_a    = dif_a[RemW-1:0];
      div_nxt.q_a[Bit] = 1'b1;
    end
    if (!dif_b[RemW]) begin
      div_nxt.rem_b    = dif_b[RemW-1:0];
      div_nxt.q_b[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= in_side;
      div_r  <= div_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_side = side_r;
  assign out_div  = div_r;
endmodule
`default_nettype wire

// ===== design/aapc_checker.sv =====
// Port-level checks of the box pair resolver, bound to its top level.
`default_nettype none
`include "aabb_pair_collision_resolve_top_defines.svh"
module aapc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_hit,
  input wire logic        out_axis,
  input wire logic [16:0] out_a_move,
  input wire logic [16:0] out_b_move
);
  `AAPC_ASSERT_NOW(a_miss_zero, out_valid && !out_hit, (out_axis == 1'b0) && (out_a_move == 17'd0) && (out_b_move == 17'd0), "miss item carries a move")
  `AAPC_ASSERT_NOW(a_opposite, out_valid && out_hit && (out_a_move != 17'd0) && (out_b_move != 17'd0), out_a_move[16] != out_b_move[16], "moves point the same way")
  `AAPC_ASSERT_NOW(a_backpress, 1'b1, in_stall == (out_valid && out_stall), "input stall not tied to held output")
  `AAPC_ASSERT_NEXT(a_hold, out_valid && out_stall, out_valid && $stable(out_a_move) && $stable(out_b_move), "stalled item changed")
endmodule

bind aabb_pair_collision_resolve_top aapc_checker u_aapc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_hit    (out_hit),
  .out_axis   (out_axis),
  .out_a_move (out_a_move),
  .out_b_move (out_b_move)
);
`default_nettype wire
